/* hw/rtl/hcpf_pkg.sv */
// ----------------------------------------------------------------------------
// hcpf_pkg
// Types and constants shared by the harmonic cutoff pair force block.
// ----------------------------------------------------------------------------
`default_nettype none

package hcpf_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned FACTOR_BITS = 16;
  localparam int unsigned NUM_FACTORS = 4;
  localparam int unsigned TABLE_DEPTH = 16;

  localparam logic [16:0] FACTOR_ONE = 17'd65536;
  localparam logic [46:0] MAG_CAP    = 47'h7FFF_FFFF_FFFF;

  // prefactor width: (64-bit delta*k times factor) >> (FACTOR_BITS + FRAC_BITS)
  localparam int unsigned PRE_W = 64 - FRAC_BITS;
  // dividend width of 2 * pre * 2^F
  localparam int unsigned DIV_W = PRE_W + FRAC_BITS + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PAIR  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [3:0]         pair_type;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic [1:0]         special_class;
    logic               last_neighbor;
    logic [31:0]        coef_k;
    logic [31:0]        coef_cut;
  } item_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic [46:0]        pair_energy;
    logic               in_range;
    logic               is_atom_total;
    logic               last;
  } result_t;

  // classified work handed from front to back
  typedef struct packed {
    logic              is_pair;
    logic [3:0]        idx;
    logic [2:0][31:0]  mag;
    logic [2:0]        neg;
    logic [16:0]       fac;
    logic              last_neighbor;
    logic [31:0]       coef_k;
    logic [31:0]       coef_cut;
  } entry_t;

  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      sat_add48 = s[48] ? {1'b1, 47'd0} : {1'b0, MAG_CAP};
    end else begin
      sat_add48 = s[47:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hcpf_front.sv */
// ----------------------------------------------------------------------------
// hcpf_front
// Accepts items, holds the special factor registers, takes displacement
// magnitudes and drops coefficient writes to unused type pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpf_front import hcpf_pkg::*; #(
  parameter int unsigned NUM_TYPES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire item_t       item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  output logic             push,
  output entry_t           push_entry,
  input  wire logic        q_full
);

  localparam int unsigned TYPE_PAIRS = NUM_TYPES * NUM_TYPES;

  logic [NUM_FACTORS-1:0][16:0] factor;
  logic [16:0] fac_sel;
  logic        idx_ok;

  assign cfg_ready  = 1'b1;
  assign item_ready = !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= {17'd0, 17'd0, 17'd0, FACTOR_ONE};
    end else if (cfg_valid && ({29'd0, cfg_index} < NUM_FACTORS)) begin
      factor[cfg_index[1:0]] <= cfg_data;
    end
  end

  always_comb begin
    fac_sel = factor[item.special_class];
    if (fac_sel > FACTOR_ONE) begin
      fac_sel = FACTOR_ONE;
    end
    idx_ok = ({5'd0, item.pair_type} < 9'(TYPE_PAIRS));
    push_entry.is_pair       = (item.op == OP_PAIR);
    push_entry.idx           = item.pair_type;
    push_entry.neg           = {item.disp_z[31], item.disp_y[31], item.disp_x[31]};
    push_entry.mag[0]        = item.disp_x[31] ? 32'(-item.disp_x) : item.disp_x;
    push_entry.mag[1]        = item.disp_y[31] ? 32'(-item.disp_y) : item.disp_y;
    push_entry.mag[2]        = item.disp_z[31] ? 32'(-item.disp_z) : item.disp_z;
    push_entry.fac           = fac_sel;
    push_entry.last_neighbor = item.last_neighbor;
    push_entry.coef_k        = item.coef_k;
    push_entry.coef_cut      = item.coef_cut;
    push = item_valid && item_ready && ((item.op == OP_PAIR) || idx_ok);
  end

endmodule

`default_nettype wire

/* hw/rtl/hcpf_queue.sv */
// ----------------------------------------------------------------------------
// hcpf_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpf_queue import hcpf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hcpf_back.sv */
// ----------------------------------------------------------------------------
// hcpf_back
// Coefficient tables and the pair force sequencer: one shared 32x32
// multiplier, bit-serial square root and divider, atom sum, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpf_back import hcpf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire entry_t head,
  output logic        pop,
  output logic        result_valid,
  input  wire logic   result_ready,
  output result_t     result
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_CSQ, S_CMP, S_SQRT, S_DELTA,
    S_DK, S_PF0, S_PF1, S_PF2, S_EN0, S_EN1, S_EN2, S_DIV, S_FPR,
    S_F0, S_F1, S_F2, S_SUM, S_EMIT, S_TOT
  } state_t;

  state_t state;

  logic [TABLE_DEPTH-1:0] tab_valid;
  logic [31:0] k_tab   [TABLE_DEPTH];
  logic [31:0] cut_tab [TABLE_DEPTH];

  logic [3:0]        idx;
  logic [2:0][31:0]  mag;
  logic [2:0]        neg;
  logic [16:0]       fac;
  logic              lastn;
  logic [1:0]        axis;
  logic [6:0]        cnt;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] tmp;
  logic [63:0] rad;
  logic [63:0] sres;
  logic [63:0] sbit;
  logic [31:0] delta;
  logic [31:0] dk_hi;
  logic [PRE_W-1:0] pre;
  logic [46:0] energy;
  logic        inr;
  logic [DIV_W-1:0] dq;
  logic [31:0] drem;
  logic [62:0] fp;
  logic signed [2:0][47:0] frc;
  logic signed [47:0] sum_x;
  logic signed [47:0] sum_y;
  logic signed [47:0] sum_z;

  logic [31:0] k_rd;
  logic [31:0] cut_rd;
  logic        slot_free;
  logic [95:0] wide;
  logic [79:0] wide_sh;
  logic [46:0] capped;
  logic [63:0] sq_try;
  logic [32:0] div_sh;

  assign k_rd      = tab_valid[idx] ? k_tab[idx]   : 32'd0;
  assign cut_rd    = tab_valid[idx] ? cut_tab[idx] : 32'd0;
  assign slot_free = !result_valid || result_ready;
  assign pop       = (state == S_IDLE) && head_valid;

  always_comb begin
    wide    = {prod, 32'd0} + {32'd0, tmp};
    wide_sh = 80'(wide >> FRAC_BITS);
    capped  = (wide_sh > {33'd0, MAG_CAP}) ? MAG_CAP : wide_sh[46:0];
    sq_try  = sres + sbit;
    div_sh  = {drem, dq[DIV_W-1]};
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state)
      S_SQX:   begin mul_a = mag[0];  mul_b = mag[0]; end
      S_SQY:   begin mul_a = mag[1];  mul_b = mag[1]; end
      S_SQZ:   begin mul_a = mag[2];  mul_b = mag[2]; end
      S_CSQ:   begin mul_a = cut_rd;  mul_b = cut_rd; end
      S_DK:    begin mul_a = delta;   mul_b = k_rd; end
      S_PF0:   begin mul_a = prod[31:0]; mul_b = {15'd0, fac}; end
      S_PF1:   begin mul_a = dk_hi;   mul_b = {15'd0, fac}; end
      S_EN0:   begin mul_a = pre[31:0]; mul_b = delta; end
      S_EN1:   begin mul_a = 32'(pre[PRE_W-1:32]); mul_b = delta; end
      S_F0:    begin mul_a = mag[axis]; mul_b = fp[31:0]; end
      S_F1:    begin mul_a = mag[axis]; mul_b = {1'b0, fp[62:32]}; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_pair) begin
      k_tab[head.idx]   <= head.coef_k;
      cut_tab[head.idx] <= head.coef_cut;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tab_valid    <= '0;
      result_valid <= 1'b0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
    end else begin
      if (result_valid && result_ready && (state != S_EMIT) && (state != S_TOT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            if (head.is_pair) begin
              idx   <= head.idx;
              mag   <= head.mag;
              neg   <= head.neg;
              fac   <= head.fac;
              lastn <= head.last_neighbor;
              state <= S_SQX;
            end else begin
              tab_valid[head.idx] <= 1'b1;
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= prod;
          state <= S_SQZ;
        end
        S_SQZ: begin
          acc   <= acc + prod;
          state <= S_CSQ;
        end
        S_CSQ: begin
          acc   <= acc + prod;
          state <= S_CMP;
        end
        S_CMP: begin
          if (acc < prod) begin
            rad   <= acc;
            sres  <= '0;
            sbit  <= 64'd1 << 62;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            frc    <= '0;
            energy <= '0;
            inr    <= 1'b0;
            state  <= S_EMIT;
          end
        end
        S_SQRT: begin
          if (rad >= sq_try) begin
            rad  <= rad - sq_try;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt + 7'd1;
          if (cnt == 7'd31) begin
            state <= S_DELTA;
          end
        end
        S_DELTA: begin
          delta <= cut_rd - sres[31:0];
          state <= S_DK;
        end
        S_DK: state <= S_PF0;
        S_PF0: begin
          dk_hi <= prod[63:32];
          state <= S_PF1;
        end
        S_PF1: begin
          tmp   <= prod;
          state <= S_PF2;
        end
        S_PF2: begin
          pre   <= PRE_W'(wide >> (FACTOR_BITS + FRAC_BITS));
          state <= S_EN0;
        end
        S_EN0: state <= S_EN1;
        S_EN1: begin
          tmp   <= prod;
          state <= S_EN2;
        end
        S_EN2: begin
          energy <= capped;
          inr    <= 1'b1;
          axis   <= 2'd0;
          if (sres[31:0] == 32'd0) begin
            fp    <= '0;
            state <= S_F0;
          end else begin
            dq    <= DIV_W'(pre) << (FRAC_BITS + 1);
            drem  <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sh >= {1'b0, sres[31:0]}) begin
            drem <= 32'(div_sh - {1'b0, sres[31:0]});
            dq   <= {dq[DIV_W-2:0], 1'b1};
          end else begin
            drem <= div_sh[31:0];
            dq   <= {dq[DIV_W-2:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'(DIV_W - 1)) begin
            state <= S_FPR;
          end
        end
        S_FPR: begin
          fp    <= (dq[DIV_W-1:63] != '0) ? {63{1'b1}} : dq[62:0];
          state <= S_F0;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          tmp   <= prod;
          state <= S_F2;
        end
        S_F2: begin
          frc[axis] <= neg[axis] ? -{1'b0, capped} : {1'b0, capped};
          if (axis == 2'd2) begin
            state <= S_SUM;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_F0;
          end
        end
        S_SUM: begin
          sum_x <= sat_add48(sum_x, frc[0]);
          sum_y <= sat_add48(sum_y, frc[1]);
          sum_z <= sat_add48(sum_z, frc[2]);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            result_valid         <= 1'b1;
            result.force_x       <= frc[0];
            result.force_y       <= frc[1];
            result.force_z       <= frc[2];
            result.pair_energy   <= energy;
            result.in_range      <= inr;
            result.is_atom_total <= 1'b0;
            result.last          <= !lastn;
            state                <= lastn ? S_TOT : S_IDLE;
          end
        end
        S_TOT: begin
          if (slot_free) begin
            result_valid         <= 1'b1;
            result.force_x       <= sum_x;
            result.force_y       <= sum_y;
            result.force_z       <= sum_z;
            result.pair_energy   <= '0;
            result.in_range      <= 1'b0;
            result.is_atom_total <= 1'b1;
            result.last          <= 1'b1;
            sum_x                <= '0;
            sum_y                <= '0;
            sum_z                <= '0;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/harmonic_cutoff_pair_force_top.sv */
// ----------------------------------------------------------------------------
// harmonic_cutoff_pair_force_top
// Harmonic cutoff pair force with per-atom force sums.
// ----------------------------------------------------------------------------
// Each neighbor pair item yields one result, plus an atom total result after
// the last neighbor; coefficient writes yield none. A two-entry queue sits
// between the front and the compute sequencer. The sequencer handles one
// pair at a time on a single 32x32 multiplier: a pair in range takes a
// 32-step square root, a 65-step divide and multiplier passes; the divide is
// skipped when r is zero, and a pair out of range skips both. Coefficient
// writes retire from the queue head in the idle state.
// ----------------------------------------------------------------------------
`default_nettype none

module harmonic_cutoff_pair_force_top import hcpf_pkg::*; #(
  parameter int unsigned NUM_TYPES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  hcpf_front #(.NUM_TYPES(NUM_TYPES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  hcpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  hcpf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

/* verif/harmonic_cutoff_pair_force_top_tb.sv */
// ----------------------------------------------------------------------------
// harmonic_cutoff_pair_force_top_tb
// Self-checking bench for the harmonic cutoff pair force block. A queue-fed
// driver streams coefficient writes and neighbor pairs. Expected pair forces,
// energies and atom totals are computed at each input transfer and compared
// in order against every output transfer. The run steps through several
// special-factor settings and handshake idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module harmonic_cutoff_pair_force_top_tb;
  import hcpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_TYPES    = 4;
  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_WAIT = 120;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FPAIR_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  harmonic_cutoff_pair_force_top #(.NUM_TYPES(N_TYPES)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0]        spring_k [TABLE_DEPTH];
  logic [31:0]        cut_len  [TABLE_DEPTH];
  logic [63:0]        cut_sq   [TABLE_DEPTH];
  logic signed [47:0] atom_sum [3];
  logic [16:0]        factor   [NUM_FACTORS];

  item_t   pending_items[$];
  result_t expected_forces[$];
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      errors = 0;
  int      n_pairs = 0;
  int      n_writes = 0;
  int      n_results = 0;
  int      n_in_range = 0;
  int      n_totals = 0;
  int      quiet_cycles = 0;
  bit      took_item = 1'b0;
  logic [31:0] gen_cut [TABLE_DEPTH];

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s,
                                            logic [63:0] cap);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p[127:64] != 0) return cap;
    return (p[63:0] > cap) ? cap : p[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bm;
    res = 0;
    bm = 64'd1 << 62;
    while (bm > v) bm = bm >> 2;
    while (bm != 0) begin
      if (v >= res + bm) begin
        v = v - (res + bm);
        res = (res >> 1) + bm;
      end else begin
        res = res >> 1;
      end
      bm = bm >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [47:0] clamp_add(logic signed [47:0] a,
                                                   logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s > 49'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (s < -49'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return s[47:0];
  endfunction

  task automatic predict_forces(item_t it);
    logic [63:0] mag [3];
    logic        neg [3];
    logic [31:0] raw;
    logic [63:0] rsq, r, delta, fac, pre, energy, fpair, num, q, rem, m;
    logic signed [47:0] f [3];
    result_t res;
    rsq = 0;
    energy = 0;
    res = '0;
    if (it.op == OP_WRITE) begin
      spring_k[it.pair_type] = it.coef_k;
      cut_len[it.pair_type]  = it.coef_cut;
      cut_sq[it.pair_type]   = {32'd0, it.coef_cut} * {32'd0, it.coef_cut};
      n_writes++;
      return;
    end
    n_pairs++;
    for (int i = 0; i < 3; i++) begin
      raw = (i == 0) ? it.disp_x : (i == 1) ? it.disp_y : it.disp_z;
      neg[i] = raw[31];
      mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
      rsq = rsq + mag[i] * mag[i];
      f[i] = '0;
    end
    if (rsq < cut_sq[it.pair_type]) begin
      r = int_sqrt(rsq);
      delta = {32'd0, cut_len[it.pair_type]} - r;
      fac = {47'd0, factor[it.special_class]};
      if (fac > 64'(FACTOR_ONE)) fac = 64'(FACTOR_ONE);
      pre = mul_shift(delta * {32'd0, spring_k[it.pair_type]}, fac,
                      FACTOR_BITS + FRAC_BITS, U64_MAX);
      energy = mul_shift(pre, delta, FRAC_BITS, 64'(MAG_CAP));
      fpair = 0;
      if (r != 0) begin
        num = pre << 1;
        q = num / r;
        rem = num % r;
        if (q >= (64'd1 << (63 - FRAC_BITS))) fpair = FPAIR_MAX;
        else fpair = (q << FRAC_BITS) + ((rem << FRAC_BITS) / r);
      end
      for (int i = 0; i < 3; i++) begin
        m = mul_shift(mag[i], fpair, FRAC_BITS, 64'(MAG_CAP));
        f[i] = neg[i] ? -$signed(m[47:0]) : $signed(m[47:0]);
        atom_sum[i] = clamp_add(atom_sum[i], f[i]);
      end
      res.in_range = 1'b1;
      n_in_range++;
    end
    res.force_x = f[0];
    res.force_y = f[1];
    res.force_z = f[2];
    res.pair_energy = energy[46:0];
    res.last = !it.last_neighbor;
    expected_forces.push_back(res);
    if (it.last_neighbor) begin
      res = '0;
      res.force_x = atom_sum[0];
      res.force_y = atom_sum[1];
      res.force_z = atom_sum[2];
      res.is_atom_total = 1'b1;
      res.last = 1'b1;
      expected_forces.push_back(res);
      for (int i = 0; i < 3; i++) atom_sum[i] = '0;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %h expected %h", n_results, what, got, want);
  endtask

  // input side: transfer bookkeeping at the rising edge, drive at the falling
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) begin
      predict_forces(item);
      took_item = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!item_valid || took_item)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
    took_item = 1'b0;
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // output side
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_forces.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(result.force_x), 64'd0);
      end else begin
        want = expected_forces.pop_front();
        if (result.force_x !== want.force_x)
          report_mismatch("force_x", 64'(result.force_x), 64'(want.force_x));
        if (result.force_y !== want.force_y)
          report_mismatch("force_y", 64'(result.force_y), 64'(want.force_y));
        if (result.force_z !== want.force_z)
          report_mismatch("force_z", 64'(result.force_z), 64'(want.force_z));
        if (result.pair_energy !== want.pair_energy)
          report_mismatch("pair_energy", 64'(result.pair_energy), 64'(want.pair_energy));
        if (result.in_range !== want.in_range)
          report_mismatch("in_range", 64'(result.in_range), 64'(want.in_range));
        if (result.is_atom_total !== want.is_atom_total)
          report_mismatch("is_atom_total", 64'(result.is_atom_total),
                          64'(want.is_atom_total));
        if (result.last !== want.last)
          report_mismatch("last", 64'(result.last), 64'(want.last));
        if (want.is_atom_total) n_totals++;
      end
      n_results++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("TIMEOUT: no transfer for %0d cycles", WDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t write_item(int idx, logic [31:0] k, logic [31:0] cut);
    item_t it;
    it.disp_x = $urandom;
    it.disp_y = $urandom;
    it.disp_z = $urandom;
    it.special_class = 2'($urandom);
    it.last_neighbor = 1'($urandom);
    it.op = OP_WRITE;
    it.pair_type = idx[3:0];
    it.coef_k = k;
    it.coef_cut = cut;
    return it;
  endfunction

  function automatic item_t pair_item(int idx, logic [31:0] dx, logic [31:0] dy,
                                      logic [31:0] dz, int cls, bit lastn);
    item_t it;
    it.op = OP_PAIR;
    it.pair_type = idx[3:0];
    it.disp_x = dx;
    it.disp_y = dy;
    it.disp_z = dz;
    it.special_class = cls[1:0];
    it.last_neighbor = lastn;
    it.coef_k = $urandom;
    it.coef_cut = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] rand_disp(int idx);
    logic [31:0] lim, m;
    lim = gen_cut[idx] >> 1;
    if (lim > 32'h7FFF_FFFF) lim = 32'h7FFF_FFFF;
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'd0;
      default: begin
        m = $urandom_range(0, lim);
        return $urandom_range(1) ? -m : m;
      end
    endcase
  endfunction

  task automatic queue_item(item_t it);
    if (it.op == OP_WRITE) gen_cut[it.pair_type] = it.coef_cut;
    pending_items.push_back(it);
  endtask

  task automatic write_factor(int idx, logic [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    factor[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_valid || expected_forces.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    int idx, nn, pairs_left;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      spring_k[i] = '0;
      cut_len[i] = '0;
      cut_sq[i] = '0;
      gen_cut[i] = '0;
    end
    for (int i = 0; i < 3; i++) atom_sum[i] = '0;
    factor[0] = FACTOR_ONE;
    factor[1] = '0;
    factor[2] = '0;
    factor[3] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, zero distance, saturation, all classes
    queue_item(pair_item(0, 32'h0001_0000, 0, 0, 0, 1'b1));
    queue_item(write_item(0, 32'h0001_0000, 32'h0002_0000));
    queue_item(write_item(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_item(write_item(5, 32'h0000_0000, 32'h0003_0000));
    queue_item(pair_item(0, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 0, 1'b0));
    queue_item(pair_item(0, 32'hFFFF_0000, 0, 0, 1, 1'b0));
    queue_item(pair_item(0, 0, 0, 0, 0, 1'b0));
    queue_item(pair_item(0, 32'h0002_0000, 0, 0, 0, 1'b1));
    queue_item(pair_item(15, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1'b0));
    queue_item(pair_item(15, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0, 1'b0));
    queue_item(pair_item(15, 32'h0000_0001, 0, 0, 0, 1'b0));
    queue_item(pair_item(15, 0, 0, 0, 0, 1'b1));
    queue_item(pair_item(5, 32'h0000_1000, 32'h0000_1000, 0, 2, 1'b0));
    queue_item(pair_item(5, 32'h0000_1000, 0, 0, 3, 1'b1));
    queue_item(pair_item(3, $urandom, $urandom, $urandom, 0, 1'b1));
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_factor(0, 17'd0);
          write_factor(1, 17'd65536);
          write_factor(2, 17'h1FFFF);
          write_factor(3, 17'd32768);
        end
        2: begin
          write_factor(0, 17'h1FFFF);
          write_factor(1, 17'd1);
          write_factor(2, 17'd65536);
          write_factor(3, 17'd0);
        end
        3, 4: for (int i = 0; i < NUM_FACTORS; i++)
          write_factor(i, 17'($urandom_range(0, 17'h1FFFF)));
        default: ;
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      if (phase == 0)
        for (int i = 0; i < TABLE_DEPTH; i++)
          queue_item(write_item(i, $urandom_range(0, 32'h0010_0000),
                                $urandom_range(32'h0001_0000, 32'h0004_0000)));
      pairs_left = 140;
      while (pairs_left > 0) begin
        if ($urandom_range(9) == 0) begin
          idx = $urandom_range(15);
          if ($urandom_range(3) == 0)
            queue_item(write_item(idx, $urandom, $urandom));
          else
            queue_item(write_item(idx, $urandom_range(0, 32'h0010_0000),
                                  $urandom_range(32'h0001_0000, 32'h0004_0000)));
        end else begin
          nn = $urandom_range(1, 6);
          for (int j = 0; j < nn; j++) begin
            idx = $urandom_range(15);
            queue_item(pair_item(idx, rand_disp(idx), rand_disp(idx), rand_disp(idx),
                                 $urandom_range(3), j == nn - 1));
          end
          pairs_left -= nn;
        end
      end
      wait_idle();
    end

    $display("Covered %0d pair transfers (%0d inside cutoff), %0d table writes,",
             n_pairs, n_in_range, n_writes);
    $display("%0d results checked including %0d atom totals, over five factor settings.",
             n_results, n_totals);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/hcpf_pkg.sv
hw/rtl/hcpf_front.sv
hw/rtl/hcpf_queue.sv
hw/rtl/hcpf_back.sv
hw/rtl/harmonic_cutoff_pair_force_top.sv
verif/harmonic_cutoff_pair_force_top_tb.sv
